### src/lgew_pkg.sv
package lgew_pkg;

	// fixed field widths of the channels
	localparam int OP_W       = 2;
	localparam int PART_IN_W  = 12;
	localparam int CELL_W     = 6;
	localparam int DIR_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int DISP_OUT_W = 16;
	localparam int SQ_OUT_W   = 32;
	localparam int SUM_W      = 44;
	localparam int CFG_W      = 7;

	// parameter defaults
	localparam int MAX_SIDE_DEF      = 64;
	localparam int MAX_PARTICLES_DEF = 4096;
	localparam int DISP_BITS_DEF     = 16;

	localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;
	localparam int               MIN_SIDE   = 2;
	localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
	localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;

	localparam logic [DIR_W-1:0] DIR_XP = 2'd0;
	localparam logic [DIR_W-1:0] DIR_YP = 2'd1;
	localparam logic [DIR_W-1:0] DIR_XM = 2'd2;
	localparam logic [DIR_W-1:0] DIR_YM = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BLOCKED  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_CONFLICT = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]      operation;
		logic [PART_IN_W-1:0] particle;
		logic [CELL_W-1:0]    cell_x;
		logic [CELL_W-1:0]    cell_y;
		logic [DIR_W-1:0]     direction;
		logic                 sweep_last;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]          status;
		logic [CELL_W-1:0]            pos_x;
		logic [CELL_W-1:0]            pos_y;
		logic signed [DISP_OUT_W-1:0] disp_x;
		logic signed [DISP_OUT_W-1:0] disp_y;
		logic [SQ_OUT_W-1:0]          sq_disp;
		logic [SUM_W-1:0]             sweep_sum;
		logic                         sum_valid;
	} result_t;

	typedef logic [CFG_W-1:0] cfg_t;

	// control of the square / sweep-sum unit
	typedef struct packed {
		logic start;
		logic clear;
		logic flush;
	} sq_ctl_t;

endpackage

### src/lgew_chan_if.sv
interface lgew_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/lgew_cellmod.sv
// cell coordinate modulo side, restoring remainder, one bit per cycle on both axes
module lgew_cellmod #(
	parameter int SIDE_W = 7,
	parameter int POS_W  = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lgew_pkg::CELL_W-1:0] in_x,
	input  logic [lgew_pkg::CELL_W-1:0] in_y,
	input  logic [SIDE_W-1:0]           side,
	output logic [POS_W-1:0]            out_x,
	output logic [POS_W-1:0]            out_y,
	output logic                        done
);
	localparam int CELL_W = lgew_pkg::CELL_W;
	localparam int RW     = (CELL_W + 1 > SIDE_W) ? CELL_W + 1 : SIDE_W;
	localparam int CNT_W  = $clog2(CELL_W);

	logic [CELL_W-1:0] vx_q, vy_q;
	logic [RW-1:0]     rx_q, ry_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [RW-1:0]     side_w, sx, sy, nx, ny;

	always_comb begin
		side_w = RW'(side);
		sx     = {rx_q[RW-2:0], vx_q[cnt_q]};
		sy     = {ry_q[RW-2:0], vy_q[cnt_q]};
		nx     = (sx >= side_w) ? sx - side_w : sx;
		ny     = (sy >= side_w) ? sy - side_w : sy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CELL_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vx_q <= in_x;
			vy_q <= in_y;
			rx_q <= '0;
			ry_q <= '0;
		end else if (busy_q) begin
			rx_q <= nx;
			ry_q <= ny;
		end
	end

	// remainder is below side, so it fits a position
	assign out_x = POS_W'(rx_q);
	assign out_y = POS_W'(ry_q);
	assign done  = done_q;
endmodule

### src/lgew_sqacc.sv
// squared displacement and saturating sweep sum, three stages
module lgew_sqacc #(
	parameter int DISP_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lgew_pkg::sq_ctl_t          ctl,
	input  logic signed [DISP_BITS-1:0] dx,
	input  logic signed [DISP_BITS-1:0] dy,
	output logic [2*DISP_BITS-1:0]     sq,
	output logic [lgew_pkg::SUM_W-1:0] acc,
	output logic                       done
);
	localparam int SUM_W = lgew_pkg::SUM_W;
	localparam int SQ_W  = 2 * DISP_BITS;
	localparam int AW    = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

	logic [DISP_BITS-1:0] mag_x, mag_y;
	logic [SQ_W-1:0]      px_s1, py_s1, sq_s2;
	logic                 v_s1, v_s2, done_q;
	logic [SUM_W-1:0]     acc_q;
	logic [AW-1:0]        sum_ext;

	always_comb begin
		// the most negative value maps onto its unsigned magnitude
		mag_x   = dx[DISP_BITS-1] ? DISP_BITS'(-dx) : DISP_BITS'(dx);
		mag_y   = dy[DISP_BITS-1] ? DISP_BITS'(-dy) : DISP_BITS'(dy);
		sum_ext = AW'(acc_q) + AW'(sq_s2);
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			px_s1 <= SQ_W'(mag_x) * SQ_W'(mag_x);
			py_s1 <= SQ_W'(mag_y) * SQ_W'(mag_y);
		end
		if (v_s1) begin
			sq_s2 <= px_s1 + py_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
			acc_q  <= '0;
		end else begin
			v_s1   <= ctl.start;
			v_s2   <= v_s1;
			done_q <= v_s2;
			if (ctl.clear || ctl.flush) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= (sum_ext > AW'(lgew_pkg::SUM_MAX)) ? lgew_pkg::SUM_MAX
					: SUM_W'(sum_ext);
			end
		end
	end

	assign sq   = sq_s2;
	assign acc  = acc_q;
	assign done = done_q;

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(ctl.start, 3))
		else $error("sum unit finished without a start three cycles back");
endmodule

### src/lgew_engine.sv
// sequencer around the occupancy grid and the particle table
module lgew_engine #(
	parameter int MAX_SIDE      = lgew_pkg::MAX_SIDE_DEF,
	parameter int MAX_PARTICLES = lgew_pkg::MAX_PARTICLES_DEF,
	parameter int DISP_BITS     = lgew_pkg::DISP_BITS_DEF,
	parameter int POS_W         = $clog2(MAX_SIDE),
	parameter int SIDE_W        = POS_W + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lgew_pkg::item_t     in_word,
	input  logic [SIDE_W-1:0]   side,
	output logic                res_valid,
	input  logic                res_take,
	output lgew_pkg::result_t   res_word
);
	localparam int PIN        = lgew_pkg::PART_IN_W;
	localparam int PIDX_W     = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int GA_W       = 2 * POS_W;
	localparam int GRID_DEPTH = 1 << GA_W;
	localparam int SQ_W       = 2 * DISP_BITS;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SWEEP = 4'd1;
	localparam logic [3:0] ST_MOD   = 4'd2;
	localparam logic [3:0] ST_PRD   = 4'd3;
	localparam logic [3:0] ST_PDEC  = 4'd4;
	localparam logic [3:0] ST_TRD   = 4'd5;
	localparam logic [3:0] ST_TGT   = 4'd6;
	localparam logic [3:0] ST_MDEC  = 4'd7;
	localparam logic [3:0] ST_MSRC  = 4'd8;
	localparam logic [3:0] ST_SQ    = 4'd9;
	localparam logic [3:0] ST_RES   = 4'd10;

	localparam logic signed [DISP_BITS-1:0] DMAX = {1'b0, {(DISP_BITS-1){1'b1}}};
	localparam logic signed [DISP_BITS-1:0] DMIN = {1'b1, {(DISP_BITS-1){1'b0}}};

	typedef struct packed {
		logic [POS_W-1:0]            x;
		logic [POS_W-1:0]            y;
		logic signed [DISP_BITS-1:0] dx;
		logic signed [DISP_BITS-1:0] dy;
	} entry_t;

	// particle index modulo MAX_PARTICLES by subtracting shifted copies
	function automatic logic [PIN-1:0] reduce_part(input logic [PIN-1:0] v);
		logic [PIN-1:0] r;
		r = v;
		for (int k = PIN - 1; k >= 0; k--) begin
			if ((MAX_PARTICLES << k) < (1 << PIN)) begin
				if (r >= PIN'(MAX_PARTICLES << k)) r = r - PIN'(MAX_PARTICLES << k);
			end
		end
		return r;
	endfunction

	logic [3:0]                  state_q;
	logic                        init_q;
	logic [GA_W-1:0]             clr_q;
	logic [lgew_pkg::OP_W-1:0]   op_q;
	logic [lgew_pkg::DIR_W-1:0]  dir_q;
	logic                        last_q;
	logic [PIDX_W-1:0]           p_q;
	logic [lgew_pkg::STATUS_W-1:0] status_q;
	logic [POS_W-1:0]            px_q, py_q, ox_q, oy_q, tx_q, ty_q;
	logic signed [DISP_BITS-1:0] dx_q, dy_q;

	// memories
	logic   grid_mem [GRID_DEPTH];
	entry_t tbl_mem [MAX_PARTICLES];
	logic   grid_rd_q;
	entry_t tbl_rd_q;

	logic            grid_we, grid_wdata, tbl_we;
	logic [GA_W-1:0] grid_waddr, grid_raddr;
	entry_t          tbl_wdata;

	logic                        accept;
	logic [POS_W-1:0]            tx_n, ty_n;
	logic [SIDE_W-1:0]           up_x, up_y;
	logic signed [DISP_BITS-1:0] ndx, ndy;
	logic [POS_W-1:0]            mx, my;
	logic                        cm_done;
	lgew_pkg::sq_ctl_t           sq_ctl;
	logic [SQ_W-1:0]             sq;
	logic [lgew_pkg::SUM_W-1:0]  acc;
	logic                        sq_done;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == ST_RES);

	// hop target from the stored position; on a plus hop a stale position past side wraps to 0
	always_comb begin
		up_x = SIDE_W'(tbl_rd_q.x) + 1'b1;
		up_y = SIDE_W'(tbl_rd_q.y) + 1'b1;
		tx_n = tbl_rd_q.x;
		ty_n = tbl_rd_q.y;
		case (dir_q)
			lgew_pkg::DIR_XP: tx_n = (up_x >= side) ? '0 : POS_W'(up_x);
			lgew_pkg::DIR_YP: ty_n = (up_y >= side) ? '0 : POS_W'(up_y);
			lgew_pkg::DIR_XM: tx_n = (tbl_rd_q.x == '0) ? POS_W'(side - 1'b1)
				: tbl_rd_q.x - 1'b1;
			default:          ty_n = (tbl_rd_q.y == '0) ? POS_W'(side - 1'b1)
				: tbl_rd_q.y - 1'b1;
		endcase
	end

	// saturating displacement step
	always_comb begin
		ndx = dx_q;
		ndy = dy_q;
		case (dir_q)
			lgew_pkg::DIR_XP: if (dx_q != DMAX) ndx = dx_q + 1'b1;
			lgew_pkg::DIR_YP: if (dy_q != DMAX) ndy = dy_q + 1'b1;
			lgew_pkg::DIR_XM: if (dx_q != DMIN) ndx = dx_q - 1'b1;
			default:          if (dy_q != DMIN) ndy = dy_q - 1'b1;
		endcase
	end

	always_comb begin
		grid_we    = 1'b0;
		grid_waddr = {px_q, py_q};
		grid_wdata = 1'b1;
		grid_raddr = {px_q, py_q};
		tbl_we     = 1'b0;
		tbl_wdata  = '{x: px_q, y: py_q, dx: '0, dy: '0};
		sq_ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				sq_ctl.clear = accept && (in_word.operation == lgew_pkg::OP_CLEAR);
			end
			ST_SWEEP: begin
				grid_we    = 1'b1;
				grid_waddr = clr_q;
				grid_wdata = 1'b0;
			end
			ST_TGT: begin
				grid_raddr = {tx_n, ty_n};
			end
			ST_PDEC: begin
				grid_we = !grid_rd_q;
				tbl_we  = !grid_rd_q;
			end
			ST_MDEC: begin
				grid_waddr   = {tx_q, ty_q};
				grid_we      = !grid_rd_q;
				tbl_we       = !grid_rd_q;
				tbl_wdata    = '{x: tx_q, y: ty_q, dx: ndx, dy: ndy};
				sq_ctl.start = grid_rd_q;
			end
			ST_MSRC: begin
				grid_waddr   = {ox_q, oy_q};
				grid_we      = 1'b1;
				grid_wdata   = 1'b0;
				sq_ctl.start = 1'b1;
			end
			ST_RES: begin
				sq_ctl.flush = res_take && last_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
		grid_rd_q <= grid_mem[grid_raddr];
	end

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[p_q] <= tbl_wdata;
		tbl_rd_q <= tbl_mem[p_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			init_q  <= 1'b1;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_word.operation)
							lgew_pkg::OP_CLEAR: state_q <= ST_SWEEP;
							lgew_pkg::OP_PLACE: state_q <= ST_MOD;
							lgew_pkg::OP_MOVE:  state_q <= ST_TRD;
							default:            state_q <= ST_RES;
						endcase
					end
				end
				ST_SWEEP: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {GA_W{1'b1}}) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_RES;
					end
				end
				ST_MOD:  if (cm_done) state_q <= ST_PRD;
				ST_PRD:  state_q <= ST_PDEC;
				ST_PDEC: state_q <= ST_RES;
				ST_TRD:  state_q <= ST_TGT;
				ST_TGT:  state_q <= ST_MDEC;
				ST_MDEC: state_q <= grid_rd_q ? ST_SQ : ST_MSRC;
				ST_MSRC: state_q <= ST_SQ;
				ST_SQ:   if (sq_done) state_q <= ST_RES;
				ST_RES:  if (res_take) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item fields and result words
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= in_word.operation;
			dir_q    <= in_word.direction;
			last_q   <= in_word.sweep_last;
			p_q      <= PIDX_W'(reduce_part(in_word.particle));
			status_q <= lgew_pkg::STAT_OK;
			px_q     <= '0;
			py_q     <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
		end
		if (state_q == ST_MOD && cm_done) begin
			px_q <= mx;
			py_q <= my;
		end
		if (state_q == ST_PDEC && grid_rd_q) begin
			status_q <= lgew_pkg::STAT_CONFLICT;
		end
		if (state_q == ST_TGT) begin
			ox_q <= tbl_rd_q.x;
			oy_q <= tbl_rd_q.y;
			tx_q <= tx_n;
			ty_q <= ty_n;
			dx_q <= tbl_rd_q.dx;
			dy_q <= tbl_rd_q.dy;
		end
		if (state_q == ST_MDEC) begin
			if (grid_rd_q) begin
				status_q <= lgew_pkg::STAT_BLOCKED;
				px_q     <= ox_q;
				py_q     <= oy_q;
			end else begin
				px_q <= tx_q;
				py_q <= ty_q;
				dx_q <= ndx;
				dy_q <= ndy;
			end
		end
	end

	lgew_cellmod #(
		.SIDE_W (SIDE_W),
		.POS_W  (POS_W)
	) u_cellmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (in_word.operation == lgew_pkg::OP_PLACE)),
		.in_x   (in_word.cell_x),
		.in_y   (in_word.cell_y),
		.side   (side),
		.out_x  (mx),
		.out_y  (my),
		.done   (cm_done)
	);

	lgew_sqacc #(
		.DISP_BITS (DISP_BITS)
	) u_sqacc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sq_ctl),
		.dx     (dx_q),
		.dy     (dy_q),
		.sq     (sq),
		.acc    (acc),
		.done   (sq_done)
	);

	always_comb begin
		res_word.status    = status_q;
		res_word.pos_x     = lgew_pkg::CELL_W'(px_q);
		res_word.pos_y     = lgew_pkg::CELL_W'(py_q);
		res_word.disp_x    = lgew_pkg::DISP_OUT_W'(dx_q);
		res_word.disp_y    = lgew_pkg::DISP_OUT_W'(dy_q);
		res_word.sq_disp   = (op_q == lgew_pkg::OP_MOVE) ? lgew_pkg::SQ_OUT_W'(sq) : '0;
		res_word.sweep_sum = acc;
		res_word.sum_valid = last_q;
	end

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !grid_we && !tbl_we)
		else $error("memory write while idle");

	a_tbl_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> !grid_rd_q)
		else $error("table written although the cell read back occupied");

	a_ready_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid)
		else $error("new word taken while a result is pending");
endmodule

### src/lattice_gas_exclusion_walker_core.sv
// channel   dir  payload                                            word taken when
// item      in   operation particle cell_x cell_y direction last    item.valid & item.ready
// result    out  status pos_x/y disp_x/y sq_disp sweep_sum valid    result.valid & result.ready
// cfg       in   side_length (7 bits)                               cfg.valid & cfg.ready
//
// One item at a time. A move reads the table, reads the grid at the target, makes
// two grid writes and the table write if the target is free, then runs the
// three-stage square/sum unit. A place runs the six-step remainder unit, a grid read
// and the writes if the cell is free; a clear writes all 2^(2*clog2(MAX_SIDE)) grid
// entries, one per cycle. After reset the same sweep runs with item.ready low;
// cfg is taken at any time. A stalled result sits in the output register while the
// next item is already being worked on.
module lattice_gas_exclusion_walker_core #(
	parameter int MAX_SIDE      = lgew_pkg::MAX_SIDE_DEF,
	parameter int MAX_PARTICLES = lgew_pkg::MAX_PARTICLES_DEF,
	parameter int DISP_BITS     = lgew_pkg::DISP_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lgew_chan_if.sink   item,
	lgew_chan_if.source result,
	lgew_chan_if.sink   cfg
);
	localparam int POS_W  = $clog2(MAX_SIDE);
	localparam int SIDE_W = POS_W + 1;

	lgew_pkg::cfg_t    side_q;
	logic [SIDE_W-1:0] side_eff;
	lgew_pkg::result_t out_q, res_word;
	logic              out_v_q;
	logic              res_valid, res_take;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= lgew_pkg::SIDE_RESET;
		end else if (cfg.valid) begin
			side_q <= cfg.data;
		end
	end

	always_comb begin
		if (int'(side_q) < lgew_pkg::MIN_SIDE) begin
			side_eff = SIDE_W'(lgew_pkg::MIN_SIDE);
		end else if (int'(side_q) > MAX_SIDE) begin
			side_eff = SIDE_W'(MAX_SIDE);
		end else begin
			side_eff = SIDE_W'(side_q);
		end
	end

	lgew_engine #(
		.MAX_SIDE      (MAX_SIDE),
		.MAX_PARTICLES (MAX_PARTICLES),
		.DISP_BITS     (DISP_BITS),
		.POS_W         (POS_W),
		.SIDE_W        (SIDE_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_word   (item.data),
		.side      (side_eff),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_word  (res_word)
	);

	// output register
	assign res_take = res_valid && (!out_v_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_take) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res_word;
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;
endmodule
